FILE: rtl/arcp_pkg.sv
// Shared types, constants and codes of the aligned range chunk planner.
package arcp_pkg;

    localparam int BALANCE_FACTOR = 4;
    localparam int MAX_WORKERS    = 7;
    localparam int RESULT_CAP     = 64;
    localparam int DIV_W          = 33;
    localparam int BND_W          = 34;
    localparam int CNT_W          = $clog2(RESULT_CAP);
    localparam int STEP_W         = $clog2(DIV_W + 1);

    typedef enum logic [1:0] {
        REG_LEAST_CHUNK  = 2'd0,
        REG_CHUNK_ALIGN  = 2'd1,
        REG_MAX_THREADS  = 2'd2,
        REG_HELPER_COUNT = 2'd3
    } arcp_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WORKERS,
        ST_CSIZE,
        ST_ALIGN,
        ST_FIRST,
        ST_EMIT
    } arcp_state_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [DIV_W-1:0] remainder;
    } div_rsp_t;

endpackage

FILE: rtl/arcp_div.sv
// Shared restoring divider that produces one quotient bit per cycle.
module arcp_div (
    input  logic               clk,
    input  logic               rst_n,
    input  arcp_pkg::div_req_t req,
    output arcp_pkg::div_rsp_t rsp
);

    logic [arcp_pkg::DIV_W-1:0]  quo_reg;
    logic [arcp_pkg::DIV_W-1:0]  quo_next;
    logic [arcp_pkg::DIV_W-1:0]  rem_reg;
    logic [arcp_pkg::DIV_W-1:0]  rem_next;
    logic [arcp_pkg::DIV_W-1:0]  dvs_reg;
    logic [arcp_pkg::DIV_W-1:0]  dvs_next;
    logic [arcp_pkg::STEP_W-1:0] step_reg;
    logic [arcp_pkg::STEP_W-1:0] step_next;
    logic                        done_reg;
    logic                        done_next;
    logic [arcp_pkg::DIV_W:0]    shifted;
    logic [arcp_pkg::DIV_W+1:0]  diff;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[arcp_pkg::DIV_W-1]};
        diff      = {1'b0, shifted} - {2'b00, dvs_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            step_next = arcp_pkg::STEP_W'(arcp_pkg::DIV_W);
        end
        else if (step_reg != '0)
        begin
            if (diff[arcp_pkg::DIV_W+1])
            begin
                rem_next = shifted[arcp_pkg::DIV_W-1:0];
            end
            else
            begin
                rem_next = diff[arcp_pkg::DIV_W-1:0];
            end
            quo_next  = {quo_reg[arcp_pkg::DIV_W-2:0], ~diff[arcp_pkg::DIV_W+1]};
            step_next = step_reg - 1'b1;
            done_next = (step_reg == arcp_pkg::STEP_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

FILE: rtl/aligned_range_chunk_planner.sv
// Top level of the aligned range chunk planner: job intake, planning sequencer, chunk output.
// A split job takes four divisions on the shared divider, then emits its chunks one by one;
// a single-chunk job takes one division and an empty job none.
// Emission stalls while the output is held off.
// The last chunk waits in the output register while the next job is taken.
// Reset is asynchronous and active low; it empties the output and loads the register defaults.
module aligned_range_chunk_planner (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // range_start [31:0], range_size [63:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,  // chunk_start [31:0], chunk_end [64:32], zero [71:65]
    output logic        m_axis_tlast,  // last_chunk
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    arcp_pkg::arcp_state_t state_reg;
    arcp_pkg::arcp_state_t state_next;
    arcp_pkg::div_req_t    div_req;
    arcp_pkg::div_rsp_t    div_rsp;

    logic [31:0] least_chunk_reg;
    logic [31:0] chunk_align_reg;
    logic [2:0]  max_threads_reg;
    logic [2:0]  helper_count_reg;

    logic [arcp_pkg::DIV_W-1:0] start_reg;
    logic [arcp_pkg::DIV_W-1:0] start_next;
    logic [31:0]                size_reg;
    logic [31:0]                size_next;
    logic [arcp_pkg::DIV_W-1:0] total_reg;
    logic [arcp_pkg::DIV_W-1:0] total_next;
    logic [arcp_pkg::DIV_W-1:0] csize_reg;
    logic [arcp_pkg::DIV_W-1:0] csize_next;
    logic [arcp_pkg::BND_W-1:0] bound_reg;
    logic [arcp_pkg::BND_W-1:0] bound_next;
    logic [arcp_pkg::CNT_W-1:0] count_reg;
    logic [arcp_pkg::CNT_W-1:0] count_next;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] out_start_reg;
    logic [31:0] out_start_next;
    logic [32:0] out_end_reg;
    logic [32:0] out_end_next;
    logic        out_last_reg;
    logic        out_last_next;

    logic [31:0] align;
    logic [2:0]  limit;
    logic [3:0]  helpers_plus;

    arcp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        align = (chunk_align_reg == '0) ? 32'd1 : chunk_align_reg;
        if (max_threads_reg == '0)
        begin
            limit = 3'd1;
        end
        else if (max_threads_reg > 3'(arcp_pkg::MAX_WORKERS))
        begin
            limit = 3'(arcp_pkg::MAX_WORKERS);
        end
        else
        begin
            limit = max_threads_reg;
        end
        helpers_plus = {1'b0, helper_count_reg} + 4'd1;
    end

    always_comb
    begin
        logic [2:0]                 workers;
        logic [2:0]                 sharing;
        logic [arcp_pkg::DIV_W-1:0] quot;
        logic [arcp_pkg::DIV_W-1:0] rounded;
        logic [arcp_pkg::DIV_W-1:0] first;
        logic [arcp_pkg::DIV_W-1:0] chunk_end;
        logic                       last;
        logic                       slot_free;

        workers   = '0;
        sharing   = '0;
        quot      = '0;
        rounded   = '0;
        first     = '0;
        chunk_end = '0;
        last      = 1'b0;
        slot_free = !out_valid_reg || m_axis_tready;

        state_next     = state_reg;
        start_next     = start_reg;
        size_next      = size_reg;
        total_next     = total_reg;
        csize_next     = csize_reg;
        bound_next     = bound_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_start_next = out_start_reg;
        out_end_next   = out_end_reg;
        out_last_next  = out_last_reg;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        s_axis_tready    = 1'b0;

        unique case (state_reg)
            arcp_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    start_next = {1'b0, s_axis_tdata[31:0]};
                    size_next  = s_axis_tdata[63:32];
                    total_next = {1'b0, s_axis_tdata[31:0]} + {1'b0, s_axis_tdata[63:32]};
                    if (s_axis_tdata[63:32] != '0)
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = {1'b0, s_axis_tdata[63:32]};
                        div_req.divisor  = {1'b0,
                            (least_chunk_reg > align) ? least_chunk_reg : align};
                        state_next = arcp_pkg::ST_WORKERS;
                    end
                end
            end
            arcp_pkg::ST_WORKERS:
            begin
                if (div_rsp.done)
                begin
                    quot = div_rsp.quotient;
                    if (quot == '0)
                    begin
                        workers = 3'd1;
                    end
                    else if (quot < {30'b0, limit})
                    begin
                        workers = quot[2:0];
                    end
                    else
                    begin
                        workers = limit;
                    end
                    count_next = '0;
                    if (workers == 3'd1)
                    begin
                        bound_next = {1'b0, total_reg};
                        state_next = arcp_pkg::ST_EMIT;
                    end
                    else
                    begin
                        sharing = ({1'b0, workers} < helpers_plus) ? workers
                                                                   : helpers_plus[2:0];
                        div_req.start    = 1'b1;
                        div_req.dividend = {1'b0, size_reg};
                        div_req.divisor  = arcp_pkg::DIV_W'(sharing)
                                         * arcp_pkg::DIV_W'(arcp_pkg::BALANCE_FACTOR);
                        state_next = arcp_pkg::ST_CSIZE;
                    end
                end
            end
            arcp_pkg::ST_CSIZE:
            begin
                if (div_rsp.done)
                begin
                    quot = div_rsp.quotient;
                    if (quot < {1'b0, least_chunk_reg})
                    begin
                        quot = {1'b0, least_chunk_reg};
                    end
                    if (quot == '0)
                    begin
                        quot = arcp_pkg::DIV_W'(1);
                    end
                    csize_next       = quot;
                    div_req.start    = 1'b1;
                    div_req.dividend = quot;
                    div_req.divisor  = {1'b0, align};
                    state_next       = arcp_pkg::ST_ALIGN;
                end
            end
            arcp_pkg::ST_ALIGN:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.remainder == '0)
                    begin
                        rounded = csize_reg;
                    end
                    else
                    begin
                        rounded = csize_reg + ({1'b0, align} - div_rsp.remainder);
                    end
                    csize_next       = rounded;
                    div_req.start    = 1'b1;
                    div_req.dividend = start_reg + arcp_pkg::DIV_W'(1);
                    div_req.divisor  = rounded;
                    state_next       = arcp_pkg::ST_FIRST;
                end
            end
            arcp_pkg::ST_FIRST:
            begin
                if (div_rsp.done)
                begin
                    first = start_reg + arcp_pkg::DIV_W'(1);
                    if (div_rsp.remainder == '0)
                    begin
                        bound_next = {1'b0, first};
                    end
                    else
                    begin
                        bound_next = {1'b0, first} + {1'b0, csize_reg - div_rsp.remainder};
                    end
                    state_next = arcp_pkg::ST_EMIT;
                end
            end
            arcp_pkg::ST_EMIT:
            begin
                if (slot_free)
                begin
                    chunk_end = (bound_reg < {1'b0, total_reg})
                              ? bound_reg[arcp_pkg::DIV_W-1:0] : total_reg;
                    last = (chunk_end == total_reg)
                        || (count_reg == arcp_pkg::CNT_W'(arcp_pkg::RESULT_CAP - 1));
                    out_valid_next = 1'b1;
                    out_start_next = start_reg[31:0];
                    out_end_next   = chunk_end;
                    out_last_next  = last;
                    start_next     = chunk_end;
                    bound_next     = {1'b0, chunk_end} + {1'b0, csize_reg};
                    count_next     = count_reg + 1'b1;
                    if (last)
                    begin
                        state_next = arcp_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = arcp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= arcp_pkg::ST_IDLE;
            out_valid_reg    <= 1'b0;
            count_reg        <= '0;
            least_chunk_reg  <= 32'd1;
            chunk_align_reg  <= 32'd1;
            max_threads_reg  <= 3'd1;
            helper_count_reg <= 3'd3;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            if (cfg_valid)
            begin
                unique case (arcp_pkg::arcp_reg_t'(cfg_index))
                    arcp_pkg::REG_LEAST_CHUNK:  least_chunk_reg  <= cfg_data;
                    arcp_pkg::REG_CHUNK_ALIGN:  chunk_align_reg  <= cfg_data;
                    arcp_pkg::REG_MAX_THREADS:  max_threads_reg  <= cfg_data[2:0];
                    arcp_pkg::REG_HELPER_COUNT: helper_count_reg <= cfg_data[2:0];
                    default:                    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg     <= start_next;
        size_reg      <= size_next;
        total_reg     <= total_next;
        csize_reg     <= csize_next;
        bound_reg     <= bound_next;
        out_start_reg <= out_start_next;
        out_end_reg   <= out_end_next;
        out_last_reg  <= out_last_next;
    end

    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, out_end_reg, out_start_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

FILE: test/tb.sv
// Self-checking testbench of the aligned range chunk planner: directed table, then random jobs.
module tb;

    localparam int LIMIT_CYCLES   = 1000000;
    localparam int SETTLE_CYCLES  = 250;
    localparam int HOLD_CYCLES    = 600;
    localparam int RAND_PHASES    = 10;
    localparam int JOBS_PER_PHASE = 30;
    localparam int HOLD_PHASE     = 3;
    localparam int N_DIR          = 21;

    typedef struct packed {
        logic [31:0] cstart;
        logic [32:0] cend;
        logic        last;
    } chunk_t;

    typedef struct packed {
        logic [31:0] least_chunk;
        logic [31:0] align;
        logic [2:0]  threads;
        logic [2:0]  helpers;
    } plan_cfg_t;

    typedef enum logic [1:0] {
        ROW_PRED,
        ROW_NONE,
        ROW_ONE
    } row_kind_t;

    typedef struct packed {
        logic [2:0]  cfg;
        logic [31:0] start;
        logic [31:0] size;
        row_kind_t   kind;
        chunk_t      want;
    } job_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    chunk_t      chunk_q[$];
    logic [31:0] sh_least;
    logic [31:0] sh_align;
    logic [2:0]  sh_threads;
    logic [2:0]  sh_helpers;
    int          errors = 0;
    int          cycles = 0;
    int          jobs_sent;
    int          chunks_seen = 0;
    int          phases;
    bit          no_idle;
    bit          hold_req;
    bit          hold_off;

    // Set 0 is the reset state and is never written.
    plan_cfg_t dir_cfgs [7] = '{
        '{32'd1,          32'd1,          3'd1, 3'd3},
        '{32'd1,          32'd0,          3'd7, 3'd6},
        '{32'd1,          32'd1,          3'd0, 3'd6},
        '{32'd4,          32'd4,          3'd7, 3'd0},
        '{32'hFFFFFFFF,   32'hFFFFFFFF,   3'd7, 3'd7},
        '{32'd0,          32'd1,          3'd7, 3'd6},
        '{32'd16,         32'h80000000,   3'd7, 3'd2}
    };

    job_row_t dir_rows [N_DIR] = '{
        '{3'd0, 32'h0,        32'h0,        ROW_NONE, '{32'h0,        33'h0,         1'b0}},
        '{3'd0, 32'h0,        32'h1,        ROW_ONE,  '{32'h0,        33'h1,         1'b1}},
        '{3'd0, 32'hFFFFFFFF, 32'hFFFFFFFF, ROW_ONE,  '{32'hFFFFFFFF, 33'h1FFFFFFFE, 1'b1}},
        '{3'd0, 32'hFFFFFFFF, 32'h1,        ROW_ONE,  '{32'hFFFFFFFF, 33'h100000000, 1'b1}},
        '{3'd0, 32'h12345678, 32'd1000,     ROW_ONE,  '{32'h12345678, 33'h012345A60, 1'b1}},
        '{3'd1, 32'h0,        32'd1000,     ROW_PRED, '0},
        '{3'd1, 32'd7,        32'd100,      ROW_PRED, '0},
        '{3'd1, 32'hFFFFFF00, 32'h100,      ROW_PRED, '0},
        '{3'd1, 32'hFFFFFFF0, 32'hFFFFFFFF, ROW_PRED, '0},
        '{3'd1, 32'h0,        32'hFFFFFFFF, ROW_PRED, '0},
        '{3'd2, 32'd100,      32'd1000,     ROW_ONE,  '{32'd100,      33'd1100,      1'b1}},
        '{3'd2, 32'h0,        32'hFFFFFFFF, ROW_ONE,  '{32'h0,        33'h0FFFFFFFF, 1'b1}},
        '{3'd3, 32'd3,        32'd200,      ROW_PRED, '0},
        '{3'd3, 32'h0,        32'd64,       ROW_PRED, '0},
        '{3'd4, 32'd5,        32'd1000,     ROW_ONE,  '{32'd5,        33'd1005,      1'b1}},
        '{3'd4, 32'h1,        32'hFFFFFFFF, ROW_ONE,  '{32'h1,        33'h100000000, 1'b1}},
        '{3'd5, 32'h0,        32'd3,        ROW_PRED, '0},
        '{3'd5, 32'd10,       32'd2,        ROW_PRED, '0},
        '{3'd5, 32'h0,        32'h0,        ROW_NONE, '0},
        '{3'd6, 32'h0,        32'hFFFFFFFF, ROW_PRED, '0},
        '{3'd6, 32'd3,        32'h40000000, ROW_PRED, '0}
    };

    aligned_range_chunk_planner DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic longint unsigned round_up(input longint unsigned v,
                                                 input longint unsigned m);
        longint unsigned r;
        r = v % m;
        return (r == 0) ? v : v + (m - r);
    endfunction

    task automatic plan_job(input logic [31:0] st, input logic [31:0] sz);
        longint unsigned base;
        longint unsigned left;
        longint unsigned algn;
        longint unsigned lim;
        longint unsigned least;
        longint unsigned divisor;
        longint unsigned workers;
        longint unsigned share;
        longint unsigned csize;
        longint unsigned len;
        longint unsigned stop;
        int              n;
        chunk_t          c;
        base  = {32'd0, st};
        left  = {32'd0, sz};
        least = {32'd0, sh_least};
        algn  = (sh_align == 0) ? 64'd1 : {32'd0, sh_align};
        lim   = (sh_threads == 0) ? 64'd1 : {61'd0, sh_threads};
        n     = 0;
        if (left == 0)
            return;
        if (lim > 64'(arcp_pkg::MAX_WORKERS))
            lim = 64'(arcp_pkg::MAX_WORKERS);
        divisor = (least > algn) ? least : algn;
        workers = left / divisor;
        if (workers < 1)
            workers = 1;
        if (workers > lim)
            workers = lim;
        if (workers == 1)
        begin
            stop     = base + left;
            c.cstart = base[31:0];
            c.cend   = stop[32:0];
            c.last   = 1'b1;
            chunk_q.push_back(c);
            return;
        end
        share = {61'd0, sh_helpers} + 64'd1;
        if (share > workers)
            share = workers;
        csize = left / (share * 64'(arcp_pkg::BALANCE_FACTOR));
        if (csize < least)
            csize = least;
        if (csize < 1)
            csize = 1;
        csize = round_up(csize, algn);
        while (left > 0 && n < arcp_pkg::RESULT_CAP)
        begin
            len = round_up(base + 1, csize) - base;
            if (len > left)
                len = left;
            stop     = base + len;
            left     = left - len;
            c.cstart = base[31:0];
            c.cend   = stop[32:0];
            c.last   = (left == 0 || n == arcp_pkg::RESULT_CAP - 1);
            chunk_q.push_back(c);
            n++;
            base = stop;
        end
    endtask

    task automatic cfg_write(input arcp_pkg::arcp_reg_t idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            arcp_pkg::REG_LEAST_CHUNK:  sh_least   = val;
            arcp_pkg::REG_CHUNK_ALIGN:  sh_align   = val;
            arcp_pkg::REG_MAX_THREADS:  sh_threads = val[2:0];
            arcp_pkg::REG_HELPER_COUNT: sh_helpers = val[2:0];
            default: ;
        endcase
    endtask

    task automatic apply_cfg(input plan_cfg_t c);
        cfg_write(arcp_pkg::REG_LEAST_CHUNK, c.least_chunk);
        cfg_write(arcp_pkg::REG_CHUNK_ALIGN, c.align);
        cfg_write(arcp_pkg::REG_MAX_THREADS, {29'd0, c.threads});
        cfg_write(arcp_pkg::REG_HELPER_COUNT, {29'd0, c.helpers});
        @(negedge clk);
        cfg_valid <= 1'b0;
        phases++;
    endtask

    // An empty job is taken while idle, so the block is idle once the last chunk is out.
    task automatic drain_jobs();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (chunk_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_job(input logic [31:0] st, input logic [31:0] sz,
                            input row_kind_t kind, input chunk_t want);
        int gap;
        gap = no_idle ? 0 : int'($urandom_range(0, 4));
        @(negedge clk);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {sz, st};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        case (kind)
            ROW_PRED: plan_job(st, sz);
            ROW_ONE:  chunk_q.push_back(want);
            default: ;
        endcase
        jobs_sent++;
    endtask

    function automatic plan_cfg_t random_cfg();
        plan_cfg_t c;
        case ($urandom_range(0, 9))
            0:       c.least_chunk = 32'd0;
            1:       c.least_chunk = 32'hFFFFFFFF;
            2:       c.least_chunk = $urandom;
            default: c.least_chunk = $urandom_range(1, 64);
        endcase
        case ($urandom_range(0, 9))
            0:       c.align = 32'd0;
            1:       c.align = 32'hFFFFFFFF;
            2:       c.align = $urandom;
            3:       c.align = 32'd1 << $urandom_range(0, 31);
            default: c.align = $urandom_range(1, 16);
        endcase
        c.threads = ($urandom_range(0, 2) == 0) ? 3'($urandom_range(0, 7))
                                                : 3'($urandom_range(4, 7));
        c.helpers = 3'($urandom_range(0, 7));
        return c;
    endfunction

    task automatic random_job();
        longint unsigned d;
        longint unsigned s;
        logic [31:0]     st;
        d = (sh_align == 0) ? 64'd1 : {32'd0, sh_align};
        if ({32'd0, sh_least} > d)
            d = {32'd0, sh_least};
        case ($urandom_range(0, 9))
            0:       s = 64'd0;
            1, 2:    s = 64'($urandom);
            3:       s = 64'($urandom_range(1, 100));
            default: s = d * 64'($urandom_range(2, 40)) + (64'($urandom) % d);
        endcase
        if (s > 64'hFFFFFFFF)
            s = 64'($urandom);
        case ($urandom_range(0, 4))
            0:       st = $urandom;
            1:       st = 32'hFFFFFFFF - $urandom_range(0, 1000);
            2:       st = 32'h0;
            default: st = $urandom_range(0, 100000);
        endcase
        send_job(st, s[31:0], ROW_PRED, '0);
    endtask

    always @(posedge clk)
    begin
        chunk_t exp_c;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            chunks_seen++;
            if (chunk_q.size() == 0)
            begin
                $error("chunk output with no chunk expected: start %h end %h",
                       m_axis_tdata[31:0], m_axis_tdata[64:32]);
                errors++;
            end
            else
            begin
                exp_c = chunk_q.pop_front();
                if (m_axis_tdata[31:0] !== exp_c.cstart)
                begin
                    $error("chunk_start: expected %h, got %h",
                           exp_c.cstart, m_axis_tdata[31:0]);
                    errors++;
                end
                if (m_axis_tdata[64:32] !== exp_c.cend)
                begin
                    $error("chunk_end: expected %h, got %h",
                           exp_c.cend, m_axis_tdata[64:32]);
                    errors++;
                end
                if (m_axis_tlast !== exp_c.last)
                begin
                    $error("last_chunk: expected %b, got %b", exp_c.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int gap;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = no_idle ? 0 : int'($urandom_range(0, 4));
            @(negedge clk);
            if (gap != 0 || hold_off)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge clk);
                while (hold_off)
                    @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
        end
    end

    initial
    begin
        hold_off = 1'b0;
        wait (hold_req);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        int cur;
        bit missing;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = arcp_pkg::REG_LEAST_CHUNK;
        cfg_data      = '0;
        sh_least      = 32'd1;
        sh_align      = 32'd1;
        sh_threads    = 3'd1;
        sh_helpers    = 3'd3;
        jobs_sent     = 0;
        phases        = 1;
        no_idle       = 1'b0;
        hold_req      = 1'b0;
        cur           = 0;
        missing       = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < N_DIR; i++)
        begin
            if (dir_rows[i].cfg != cur)
            begin
                drain_jobs();
                cur = dir_rows[i].cfg;
                apply_cfg(dir_cfgs[cur]);
            end
            send_job(dir_rows[i].start, dir_rows[i].size, dir_rows[i].kind, dir_rows[i].want);
        end

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            drain_jobs();
            apply_cfg(random_cfg());
            no_idle = (p % 4 == 2);
            if (p == HOLD_PHASE)
                hold_req = 1'b1;
            for (int j = 0; j < JOBS_PER_PHASE; j++)
                random_job();
        end

        drain_jobs();
        if (chunk_q.size() != 0)
        begin
            $error("%0d chunks never arrived", chunk_q.size());
            missing = 1'b1;
        end
        $display("Sent %0d jobs over %0d register settings and checked %0d chunks.",
                 jobs_sent, phases, chunks_seen);
        $display("Covered empty, whole-range and split jobs, 33-bit ends and a long stall.");
        if (errors == 0 && !missing)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
